>>> sv/nma_pkg.sv
// ============================================================================
// nma_pkg
// Shared types and constants for the nearest-medoid assignment block.
// ============================================================================
package nma_pkg;

    localparam int COORD_W = 16;
    localparam int LABEL_W = 7;
    localparam int DIST_W  = 38;
    localparam int SQ_W    = 32;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Input item kinds carried on the slave-side tuser.
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_POINT = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    // Configuration register indexes.
    localparam logic REG_MEDOID_COUNT = 1'b0;
    localparam logic REG_DIM_COUNT    = 1'b1;

    // Store and valid-bit commands broadcast to every cell at acceptance.
    typedef struct packed {
        logic               wr_en;
        logic [LABEL_W-1:0] wr_slot;
        logic               wr_last;
        logic               rd_en;
        logic               clear;
    } load_cmd_t;

    // Distance pipeline controls broadcast to every cell.
    typedef struct packed {
        logic signed [COORD_W-1:0] point_val;
        logic                      acc_en;
        logic                      acc_first;
    } pipe_ctl_t;

    // Running minimum handed from cell to cell.
    typedef struct packed {
        logic               valid;
        logic               found;
        logic [LABEL_W-1:0] label;
        logic [DIST_W-1:0]  distance;
    } token_t;

endpackage

>>> sv/nma_ram.sv
// ============================================================================
// nma_ram
// Generic single-port RAM with registered read data.
// ============================================================================
module nma_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

>>> sv/nma_cell.sv
// ============================================================================
// nma_cell
// One medoid slot: coordinate store, distance accumulator and compare stage.
// ============================================================================
module nma_cell
    import nma_pkg::*;
#(
    parameter int DIMS  = 64,
    localparam int AW   = (DIMS > 1) ? $clog2(DIMS) : 1
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [LABEL_W-1:0]        cell_id,
    input  logic                      active,
    input  load_cmd_t                 cmd,
    input  logic [AW-1:0]             addr,
    input  logic signed [COORD_W-1:0] wdata,
    input  pipe_ctl_t                 pipe,
    input  logic                      shift_en,
    input  token_t                    token_in,
    output token_t                    token_out
);

    logic                      hit;
    logic signed [COORD_W-1:0] coord;
    logic signed [COORD_W:0]   diff;
    logic [COORD_W:0]          mag;
    logic [COORD_W-1:0]        absd_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [DIST_W-1:0]         base;
    logic [DIST_W:0]           sum_ext;
    logic [DIST_W-1:0]         sum_reg;
    logic [DIST_W-1:0]         sum_next;
    logic                      valid_reg;
    logic                      valid_next;
    logic                      take;
    token_t                    token_next;

    assign hit = cmd.wr_en && (cmd.wr_slot == cell_id);

    nma_ram
    #(
        .WIDTH (COORD_W),
        .DEPTH (DIMS)
    )
    u_store
    (
        .clk   (clk),
        .we    (hit),
        .re    (cmd.rd_en),
        .addr  (addr),
        .wdata (wdata),
        .rdata (coord)
    );

    // Absolute difference always fits in COORD_W bits.
    always_comb
    begin
        diff = (COORD_W+1)'(pipe.point_val) - (COORD_W+1)'(coord);
        mag  = diff[COORD_W] ? (COORD_W+1)'(-diff) : (COORD_W+1)'(diff);
    end

    always_ff @(posedge clk)
    begin
        absd_reg <= mag[COORD_W-1:0];
        sq_reg   <= absd_reg * absd_reg;
    end

    // Coordinate zero restarts the sum; the sum saturates at the top.
    always_comb
    begin
        base     = pipe.acc_first ? '0 : sum_reg;
        sum_ext  = {1'b0, base} + (DIST_W+1)'(sq_reg);
        sum_next = sum_reg;
        if (pipe.acc_en && active)
        begin
            sum_next = sum_ext[DIST_W] ? DIST_MAX : sum_ext[DIST_W-1:0];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        priority if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (hit && cmd.wr_last)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // Strict less-than keeps the lower slot on ties.
    always_comb
    begin
        take       = active && valid_reg && (!token_in.found || (sum_reg < token_in.distance));
        token_next = token_in;
        if (take)
        begin
            token_next.found    = 1'b1;
            token_next.label    = cell_id;
            token_next.distance = sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            valid_reg <= 1'b0;
            token_out <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            valid_reg <= valid_next;
            if (shift_en)
            begin
                token_out <= token_next;
            end
        end
    end

endmodule

>>> sv/nearest_medoid_assign_top.sv
// ============================================================================
// nearest_medoid_assign_top
// Nearest-medoid classifier: squared Euclidean distance over a row of cells.
// ============================================================================
//
//  Channel   Signals                                   Direction  Content
//  --------  ----------------------------------------  ---------  -----------------------
//  input     s_tvalid s_tready s_tdata s_tuser         in         load / point / clear
//  result    m_tvalid m_tready m_tdata m_tuser         out        label, distance, flag
//  config    cfg_we cfg_index cfg_data                 in         medoid and dim counts
//
//  Loads, clears and every point coordinate but the last are taken one item per
//  cycle. The last coordinate of a point holds off the input until its result is
//  stored: it passes distance pipeline stages A, B and C and launch stage D, then
//  the running minimum walks the chain of medoid cells. The result sits in an
//  output register, so the next input item is taken while it waits; if the result
//  register is still full when the next minimum reaches the end of the chain, the
//  chain holds until the result is taken. Reset clears all valid bits and running
//  sums; coordinate stores are not cleared and must be loaded before use.
//
module nearest_medoid_assign_top
    import nma_pkg::*;
#(
    parameter int MAX_MEDOIDS = 128,
    parameter int MAX_DIMS    = 64
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // medoid_slot[6:0], dim_index[12:7], coord_value[28:13]
    input  logic [1:0]  s_tuser,   // opcode[1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // label[6:0], distance_sq[44:7]
    output logic        m_tuser,   // none_valid[0]

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DW = $clog2(MAX_DIMS + 1);
    localparam int CW = (DW > 7) ? DW : 7;

    // Unpacked input item fields.
    opcode_t                   opcode;
    logic [LABEL_W-1:0]        medoid_slot;
    logic [5:0]                dim_index;
    logic signed [COORD_W-1:0] coord_value;

    logic [7:0]    medoid_count_reg;
    logic [7:0]    medoid_count_next;
    logic [6:0]    dimension_count_reg;
    logic [6:0]    dimension_count_next;
    logic [CW-1:0] dims_eff;
    logic          in_shape;
    logic          last_dim;
    logic          accept;
    logic          point_ok;

    load_cmd_t     cmd;
    pipe_ctl_t     pipe;
    logic [AW-1:0] addr;

    // Distance pipeline control: stage A after the store read, B after the
    // absolute difference, C after the square (accumulate), D launches the search.
    logic                      pa_valid_reg, pb_valid_reg, pc_valid_reg;
    logic                      pa_first_reg, pb_first_reg, pc_first_reg;
    logic                      pa_last_reg,  pb_last_reg,  pc_last_reg;
    logic                      pd_launch_reg;
    logic signed [COORD_W-1:0] pa_val_reg;

    logic   busy_reg;
    logic   busy_next;
    logic   shift_en;
    logic   out_load;
    token_t chain [MAX_MEDOIDS+1];

    logic               out_valid_reg;
    logic [LABEL_W-1:0] label_reg;
    logic [DIST_W-1:0]  distance_sq_reg;
    logic               none_valid_reg;

    assign opcode      = opcode_t'(s_tuser);
    assign medoid_slot = s_tdata[6:0];
    assign dim_index   = s_tdata[12:7];
    assign coord_value = signed'(s_tdata[28:13]);

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !busy_reg;

    // Effective dimension count: zero counts as one, large values clip.
    always_comb
    begin
        priority if (dimension_count_reg == 7'd0)
        begin
            dims_eff = CW'(1);
        end
        else if (CW'(dimension_count_reg) > CW'(MAX_DIMS))
        begin
            dims_eff = CW'(MAX_DIMS);
        end
        else
        begin
            dims_eff = CW'(dimension_count_reg);
        end
    end

    assign in_shape = CW'(dim_index) < dims_eff;
    assign last_dim = CW'(dim_index) == (dims_eff - CW'(1));
    assign point_ok = accept && (opcode == OP_POINT) && in_shape;
    assign addr     = AW'(dim_index);

    always_comb
    begin
        cmd.wr_en   = accept && (opcode == OP_LOAD) && in_shape;
        cmd.wr_slot = medoid_slot;
        cmd.wr_last = last_dim;
        cmd.rd_en   = point_ok;
        cmd.clear   = accept && (opcode == OP_CLEAR);
    end

    always_comb
    begin
        pipe.point_val = pa_val_reg;
        pipe.acc_en    = pc_valid_reg;
        pipe.acc_first = pc_first_reg;
    end

    // Configuration registers.
    always_comb
    begin
        medoid_count_next    = medoid_count_reg;
        dimension_count_next = dimension_count_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MEDOID_COUNT: medoid_count_next    = cfg_data;
                REG_DIM_COUNT:    dimension_count_next = cfg_data[6:0];
                default:          medoid_count_next    = medoid_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            medoid_count_reg    <= 8'd2;
            dimension_count_reg <= 7'd1;
        end
        else
        begin
            medoid_count_reg    <= medoid_count_next;
            dimension_count_reg <= dimension_count_next;
        end
    end

    // Distance pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pa_valid_reg  <= 1'b0;
            pb_valid_reg  <= 1'b0;
            pc_valid_reg  <= 1'b0;
            pa_first_reg  <= 1'b0;
            pb_first_reg  <= 1'b0;
            pc_first_reg  <= 1'b0;
            pa_last_reg   <= 1'b0;
            pb_last_reg   <= 1'b0;
            pc_last_reg   <= 1'b0;
            pd_launch_reg <= 1'b0;
        end
        else
        begin
            pa_valid_reg  <= point_ok;
            pa_first_reg  <= dim_index == 6'd0;
            pa_last_reg   <= last_dim;
            pb_valid_reg  <= pa_valid_reg;
            pb_first_reg  <= pa_first_reg;
            pb_last_reg   <= pa_last_reg;
            pc_valid_reg  <= pb_valid_reg;
            pc_first_reg  <= pb_first_reg;
            pc_last_reg   <= pb_last_reg;
            pd_launch_reg <= pc_valid_reg && pc_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_val_reg <= coord_value;
    end

    // The minimum search enters the first cell with nothing found yet.
    always_comb
    begin
        chain[0].valid    = pd_launch_reg;
        chain[0].found    = 1'b0;
        chain[0].label    = '0;
        chain[0].distance = '0;
    end

    // The chain holds only when a finished result cannot leave its last cell.
    assign out_load = chain[MAX_MEDOIDS].valid && (!out_valid_reg || m_tready);
    assign shift_en = !chain[MAX_MEDOIDS].valid || out_load;

    for (genvar m = 0; m < MAX_MEDOIDS; m++)
    begin : g_cell
        logic active;

        assign active = 8'(m) < medoid_count_reg;

        nma_cell
        #(
            .DIMS (MAX_DIMS)
        )
        u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_id   (LABEL_W'(m)),
            .active    (active),
            .cmd       (cmd),
            .addr      (addr),
            .wdata     (coord_value),
            .pipe      (pipe),
            .shift_en  (shift_en),
            .token_in  (chain[m]),
            .token_out (chain[m+1])
        );
    end

    // Input is held off from a final point coordinate until its result is stored.
    always_comb
    begin
        busy_next = busy_reg;
        priority if (point_ok && last_dim)
        begin
            busy_next = 1'b1;
        end
        else if (out_load)
        begin
            busy_next = 1'b0;
        end
        else
        begin
            busy_next = busy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            priority if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= out_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            label_reg       <= chain[MAX_MEDOIDS].label;
            distance_sq_reg <= chain[MAX_MEDOIDS].distance;
            none_valid_reg  <= !chain[MAX_MEDOIDS].found;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, distance_sq_reg, label_reg};
    assign m_tuser  = none_valid_reg;

endmodule

>>> sim/nma_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// nma_checker
// Watches the input, result and register channels of the nearest-medoid
// block, predicts every label it should give and compares them as they leave.
// ============================================================================
module nma_checker
    import nma_pkg::*;
#(
    parameter int MAX_MEDOIDS = 128,
    parameter int MAX_DIMS    = 64
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // medoid_slot[6:0], dim_index[12:7], coord_value[28:13]
    input  logic [1:0]  s_tuser,   // opcode[1:0]

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // label[6:0], distance_sq[44:7]
    input  logic        m_tuser,   // none_valid[0]

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,

    output int          fail_count,
    output int          results_pending,
    output int          results_checked
);

    typedef struct {
        logic [LABEL_W-1:0] label;
        logic [DIST_W-1:0]  distance;
        logic               none_valid;
    } assignment_t;

    logic signed [COORD_W-1:0] medoid_store [MAX_MEDOIDS][MAX_DIMS];
    logic                      slot_valid   [MAX_MEDOIDS];
    longint                    running_sum  [MAX_MEDOIDS];
    logic [7:0]                medoid_count_reg;
    logic [6:0]                dim_count_reg;
    assignment_t               expected_labels [$];

    initial
    begin
        fail_count      = 0;
        results_pending = 0;
        results_checked = 0;
    end

    function automatic int searched_slots();
        searched_slots = (int'(medoid_count_reg) > MAX_MEDOIDS) ? MAX_MEDOIDS
                                                                : int'(medoid_count_reg);
    endfunction

    function automatic int active_dims();
        if (dim_count_reg == 7'd0)
            active_dims = 1;
        else if (int'(dim_count_reg) > MAX_DIMS)
            active_dims = MAX_DIMS;
        else
            active_dims = int'(dim_count_reg);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (fail_count < 40)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Advances the prediction by one accepted item; the last point coordinate
    // queues the nearest valid slot.
    task automatic score_item(input logic [1:0] op, input logic [6:0] slot,
                              input logic [5:0] dim, input logic signed [15:0] val);
        int          dims;
        int          count;
        longint      diff;
        longint      acc;
        bit          found;
        assignment_t nearest;
        dims  = active_dims();
        count = searched_slots();
        found = 1'b0;
        nearest.label      = '0;
        nearest.distance   = '0;
        nearest.none_valid = 1'b1;
        if (op == OP_CLEAR)
        begin
            for (int m = 0; m < MAX_MEDOIDS; m++)
                slot_valid[m] = 1'b0;
        end
        else if (op == OP_LOAD)
        begin
            if (int'(slot) < MAX_MEDOIDS && int'(dim) < dims)
            begin
                medoid_store[slot][dim] = val;
                if (int'(dim) == dims - 1)
                    slot_valid[slot] = 1'b1;
            end
        end
        else if (op == OP_POINT && int'(dim) < dims)
        begin
            for (int m = 0; m < count; m++)
            begin
                diff = longint'(val) - longint'(medoid_store[m][dim]);
                acc  = (dim == 6'd0) ? 64'sd0 : running_sum[m];
                acc  = acc + diff * diff;
                if (acc > longint'(DIST_MAX))
                    acc = longint'(DIST_MAX);
                running_sum[m] = acc;
            end
            if (int'(dim) == dims - 1)
            begin
                for (int m = 0; m < count; m++)
                begin
                    if (slot_valid[m] && (!found || running_sum[m] < longint'(nearest.distance)))
                    begin
                        found              = 1'b1;
                        nearest.label      = m[LABEL_W-1:0];
                        nearest.distance   = running_sum[m][DIST_W-1:0];
                        nearest.none_valid = 1'b0;
                    end
                end
                expected_labels.push_back(nearest);
            end
        end
    endtask

    task automatic check_result();
        assignment_t want;
        if (expected_labels.size() == 0)
        begin
            report_mismatch("result with nothing pending (label)", longint'(m_tdata[6:0]), -1);
        end
        else
        begin
            want = expected_labels.pop_front();
            results_checked++;
            if (m_tdata[6:0] !== want.label)
                report_mismatch("label", longint'(m_tdata[6:0]), longint'(want.label));
            if (m_tdata[44:7] !== want.distance)
                report_mismatch("distance_sq", longint'(m_tdata[44:7]), longint'(want.distance));
            if (m_tuser !== want.none_valid)
                report_mismatch("none_valid", longint'(m_tuser), longint'(want.none_valid));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < MAX_MEDOIDS; m++)
            begin
                slot_valid[m]  = 1'b0;
                running_sum[m] = 0;
                for (int d = 0; d < MAX_DIMS; d++)
                    medoid_store[m][d] = '0;
            end
            medoid_count_reg = 8'd2;
            dim_count_reg    = 7'd1;
            expected_labels.delete();
            results_pending  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_MEDOID_COUNT)
                    medoid_count_reg = cfg_data;
                else
                    dim_count_reg = cfg_data[6:0];
            end
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                score_item(s_tuser, s_tdata[6:0], s_tdata[12:7], s_tdata[28:13]);
            results_pending = expected_labels.size();
        end
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Stimulus and verdict for the nearest-medoid classifier. A checker beside the
// block predicts each label and reports mismatches; this module loads medoids,
// streams points under varying idle and stall patterns and changes the
// register settings between phases.
// ============================================================================
module tb;
    import nma_pkg::*;

    localparam int MAX_MEDOIDS = 128;
    localparam int MAX_DIMS    = 64;

    // The last coordinate of a point keeps the block busy while its minimum
    // walks the chain of cells; this margin covers that walk with room to spare.
    localparam int SETTLE_CYCLES = MAX_MEDOIDS + 24;

    // Opcode that the block must ignore; the package names only the used ones.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Register settings of the random phases, raw values as written. Several
    // lie outside the documented range so that the clamping is exercised.
    localparam int PHASES = 10;
    localparam int PHASE_MEDOIDS [PHASES] = '{2, 0, 1, 128, 255, 7, 3, 200, 64, 129};
    localparam int PHASE_DIMS    [PHASES] = '{1, 3, 2, 64, 127, 0, 5, 65, 4, 8};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    int fail_count;
    int results_pending;
    int results_checked;

    // Idle and stall chances in percent per cycle, set per phase.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    // Effective register values, tracked here only to shape the stimulus.
    int slots_in_use;
    int dims_in_use;

    int  items_sent;
    int  loads_sent;
    int  coords_sent;
    int  clears_sent;
    int  unused_sent;
    int  settings_run;
    bit  drained_once;

    // The coordinate store is not cleared by reset. Every slot made valid in a
    // phase is loaded whole first, and a point may continue the running sums
    // only when no load came since the last restart at dimension 0, so no
    // result ever depends on an unwritten coordinate.
    int  last_full_slot;
    bit  sums_fresh;

    // Coordinates of the medoid loaded last, so points can be aimed near it.
    logic signed [COORD_W-1:0] medoid_buf [MAX_DIMS];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The result side stalls independently of the input side.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);

    nearest_medoid_assign_top #(
        .MAX_MEDOIDS (MAX_MEDOIDS),
        .MAX_DIMS    (MAX_DIMS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nma_checker #(
        .MAX_MEDOIDS (MAX_MEDOIDS),
        .MAX_DIMS    (MAX_DIMS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .results_pending (results_pending),
        .results_checked (results_checked)
    );

    // Offers one item and returns at the edge where it is taken. A gap lowers
    // tvalid only when one is actually taken, so back-to-back items keep it
    // high without a second assignment in the same step.
    task automatic send_item(input logic [1:0] op, input int slot, input int dim,
                             input logic signed [15:0] val);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, val, dim[5:0], slot[6:0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        case (op)
            OP_LOAD:  loads_sent++;
            OP_POINT: coords_sent++;
            OP_CLEAR: clears_sent++;
            default:  unused_sent++;
        endcase
    endtask

    // Holds the input off until every predicted label has left the block,
    // then waits the given number of cycles more. The checker's count is
    // read on the falling edge, when all of the edge's updates have settled.
    task automatic hold_until_drained(input int extra_cycles);
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (results_pending != 0)
            @(negedge clk);
        repeat (extra_cycles + 1)
            @(posedge clk);
    endtask

    // Writes both registers; only called while the block is idle.
    task automatic set_registers(input int medoids, input int dims);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MEDOID_COUNT;
        cfg_data  <= medoids[7:0];
        @(posedge clk);
        cfg_index <= REG_DIM_COUNT;
        cfg_data  <= {1'b0, dims[6:0]};
        @(posedge clk);
        cfg_we    <= 1'b0;
        slots_in_use = (medoids[7:0] > MAX_MEDOIDS) ? MAX_MEDOIDS : medoids[7:0];
        if (dims[6:0] == 0)
            dims_in_use = 1;
        else
            dims_in_use = (dims[6:0] > MAX_DIMS) ? MAX_DIMS : dims[6:0];
        settings_run++;
    endtask

    // Coordinates lean toward the two extremes and toward small values.
    function automatic logic signed [15:0] pick_coord();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            pick_coord = 16'sh8000;
        else if (r < 24)
            pick_coord = 16'sh7FFF;
        else if (r < 50)
            pick_coord = 16'($urandom_range(255)) - 16'd128;
        else
            pick_coord = 16'($urandom);
    endfunction

    // Mostly a slot that takes part in the search, now and then any slot.
    function automatic int pick_slot();
        if (slots_in_use == 0 || $urandom_range(9) == 0)
            pick_slot = $urandom_range(MAX_MEDOIDS - 1);
        else
            pick_slot = $urandom_range(slots_in_use - 1);
    endfunction

    // Loads a whole medoid in dimension order, optionally a second slot with
    // the same coordinates so that the two tie on every point.
    task automatic load_medoid(input int slot, input bit extreme, input bit twin,
                               input int twin_slot);
        sums_fresh     = 1'b0;
        last_full_slot = slot;
        for (int d = 0; d < dims_in_use; d++)
        begin
            medoid_buf[d] = extreme ? 16'sh8000 : pick_coord();
            send_item(OP_LOAD, slot, d, medoid_buf[d]);
        end
        if (twin)
        begin
            for (int d = 0; d < dims_in_use; d++)
                send_item(OP_LOAD, twin_slot, d, medoid_buf[d]);
        end
    endtask

    // Streams point coordinates first..last in ascending order. A near point
    // sits within a few steps of the last loaded medoid; an extreme point has
    // every coordinate at the top of the range.
    task automatic send_point(input int first, input int last, input bit near,
                              input bit extreme);
        logic signed [15:0] v;
        if (first == 0)
            sums_fresh = 1'b1;
        for (int d = first; d <= last; d++)
        begin
            if (extreme)
                v = 16'sh7FFF;
            else if (near)
                v = medoid_buf[d] + 16'($urandom_range(6)) - 16'd3;
            else
                v = pick_coord();
            send_item(OP_POINT, 0, d, v);
        end
    endtask

    // One random phase. Most of it is whole medoid loads and whole points;
    // the rest is clears, ignored items and broken or shifted point streams.
    // Only items the block acts on count toward the budget.
    task automatic run_random(input int budget);
        int used;
        int r;
        int k;
        bit twin;
        used = 0;
        while (used < budget)
        begin
            r = $urandom_range(99);
            if (r < 25)
            begin
                twin = ($urandom_range(4) == 0);
                load_medoid(pick_slot(), $urandom_range(9) == 0, twin, pick_slot());
                used += twin ? 2 * dims_in_use : dims_in_use;
            end
            else if (r < 72)
            begin
                send_point(0, dims_in_use - 1, $urandom_range(2) == 0,
                           $urandom_range(11) == 0);
                used += dims_in_use;
                // Let the pipeline run empty now and then with the input idle.
                if (!drained_once || $urandom_range(29) == 0)
                begin
                    hold_until_drained(0);
                    drained_once = 1'b1;
                end
            end
            else if (r < 77)
            begin
                send_item(OP_CLEAR, $urandom_range(127), $urandom_range(63), pick_coord());
                used++;
            end
            else
            begin
                case ($urandom_range(5))
                    0:
                        send_item(OP_UNUSED, $urandom_range(127), $urandom_range(63),
                                  pick_coord());
                    1:
                        if (dims_in_use < MAX_DIMS)
                            send_item(OP_LOAD, pick_slot(),
                                      $urandom_range(MAX_DIMS - 1, dims_in_use), pick_coord());
                        else
                            send_item(OP_UNUSED, 0, 0, pick_coord());
                    2:
                        if (dims_in_use < MAX_DIMS)
                            send_item(OP_POINT, $urandom_range(127),
                                      $urandom_range(MAX_DIMS - 1, dims_in_use), pick_coord());
                        else
                            send_item(OP_UNUSED, $urandom_range(127), 63, pick_coord());
                    3:
                    begin
                        // A point cut short; whole if only one dimension.
                        k = (dims_in_use > 1) ? $urandom_range(dims_in_use - 2) : 0;
                        send_point(0, k, 1'b0, 1'b0);
                        used += k + 1;
                    end
                    4:
                    begin
                        // A point that may skip dimension 0 and so keep adding
                        // to the running sums of the point before it.
                        k = (dims_in_use > 1 && sums_fresh) ?
                            $urandom_range(dims_in_use - 1, 1) : 0;
                        send_point(k, dims_in_use - 1, 1'b0, 1'b0);
                        used += dims_in_use - k;
                    end
                    default:
                    begin
                        // Writing only the last coordinate of a loaded slot
                        // marks it valid again.
                        if (last_full_slot >= 0)
                        begin
                            send_item(OP_LOAD, last_full_slot, dims_in_use - 1, pick_coord());
                            sums_fresh = 1'b0;
                            used++;
                        end
                        else
                            send_item(OP_UNUSED, 0, 0, pick_coord());
                    end
                endcase
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_LOAD;
        cfg_we         = 1'b0;
        cfg_index      = REG_MEDOID_COUNT;
        cfg_data       = '0;
        items_sent     = 0;
        loads_sent     = 0;
        coords_sent    = 0;
        clears_sent    = 0;
        unused_sent    = 0;
        settings_run   = 0;
        drained_once   = 1'b0;
        last_full_slot = -1;
        sums_fresh     = 1'b0;
        slots_in_use   = 2;
        dims_in_use    = 1;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed, full shape: no valid slot, the top slot and the top
        // dimension, both coordinate extremes, and points that start at the
        // last dimension and so accumulate instead of restarting, one of them
        // driving a running sum into saturation.
        set_registers(MAX_MEDOIDS, MAX_DIMS);
        send_item(OP_CLEAR, 0, 0, 16'sd0);
        send_item(OP_POINT, 0, 63, 16'sd0);
        for (int d = 0; d < MAX_DIMS; d++)
            send_item(OP_LOAD, 127, d, 16'sh7FFF);
        load_medoid(5, 1'b1, 1'b0, 0);
        send_point(0, MAX_DIMS - 1, 1'b0, 1'b1);
        send_item(OP_POINT, 0, 63, 16'sh7FFF);
        send_item(OP_POINT, 0, 63, 16'sh8000);
        hold_until_drained(SETTLE_CYCLES);

        // Directed, small shape: two identical medoids tie and the lower slot
        // must win, an unused opcode, a load and a point outside the shape, a
        // slot made valid again by its last coordinate alone, and a valid slot
        // that lies beyond the searched range.
        set_registers(3, 2);
        send_item(OP_CLEAR, 127, 63, 16'sh7FFF);
        send_item(OP_LOAD, 0, 0, 16'sd100);
        send_item(OP_LOAD, 0, 1, -16'sd100);
        send_item(OP_LOAD, 1, 0, 16'sd100);
        send_item(OP_LOAD, 1, 1, -16'sd100);
        send_item(OP_LOAD, 2, 0, -16'sd7);
        send_item(OP_LOAD, 2, 1, 16'sd5);
        send_item(OP_POINT, 0, 0, 16'sd100);
        send_item(OP_POINT, 0, 1, -16'sd100);
        send_item(OP_POINT, 0, 1, 16'sd7);
        send_item(OP_UNUSED, 127, 63, 16'sh8000);
        send_item(OP_LOAD, 127, 63, 16'sd1);
        send_item(OP_POINT, 0, 63, 16'sd1);
        send_item(OP_CLEAR, 0, 0, 16'sd0);
        send_item(OP_LOAD, 2, 1, 16'sd5);
        send_item(OP_LOAD, 127, 0, 16'sd0);
        send_item(OP_LOAD, 127, 1, 16'sd0);
        send_item(OP_POINT, 0, 0, 16'sh8000);
        send_item(OP_POINT, 0, 1, 16'sh7FFF);
        hold_until_drained(SETTLE_CYCLES);

        // Random phases, rotating through the idle and stall patterns. Each
        // phase starts with every slot invalid.
        for (int p = 0; p < PHASES; p++)
        begin
            set_registers(PHASE_MEDOIDS[p], PHASE_DIMS[p]);
            send_item(OP_CLEAR, 0, 0, 16'sd0);
            last_full_slot = -1;
            sums_fresh     = 1'b0;
            case (p % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 53;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 53;
                end
                default:
                begin
                    sender_idle_pct    = 10;
                    receiver_stall_pct = 10;
                end
            endcase
            run_random((dims_in_use == MAX_DIMS) ? 160 : 35);
            hold_until_drained(SETTLE_CYCLES);
        end

        $display("Covered %0d items: %0d loads, %0d point coordinates, %0d clears, %0d ignored",
                 items_sent, loads_sent, coords_sent, clears_sent, unused_sent);
        $display("over %0d register settings; %0d labels compared, %0d mismatches.",
                 settings_run, results_checked, fail_count);
        if (fail_count == 0 && results_pending == 0)
            $display("** nearest_medoid_assign_top: PASSED **");
        else
            $display("** nearest_medoid_assign_top: FAILED **");
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        #20_000_000;
        $display("Timeout with %0d labels still pending.", results_pending);
        $display("** nearest_medoid_assign_top: FAILED **");
        $finish;
    end

endmodule
